// ===== src/bps_pkg.sv =====
// Package for the bilinear pixel sampler: field widths, register map and codes.
// No dependencies; imported by bilinear_pixel_sampler_unit.
package bps_pkg;

    // Fixed widths of the word fields and of the configuration registers.
    localparam int OP_W          = 1;
    localparam int PIX_COORD_W   = 9;
    localparam int PIX_W         = 8;
    localparam int SAMPLE_W      = 17;
    localparam int REG_W         = 10;
    localparam int PDATA_W       = 32;
    localparam int PADDR_W       = 3;

    // Width used for coordinate compares: holds a sample's integer part plus one
    // and any frame size up to the largest supported.
    localparam int CMP_W         = 18;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 8;

    // Largest value a configuration register can hold.
    localparam int REG_MAX       = (1 << REG_W) - 1;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // Register index as decoded from paddr[2] (registers at byte 0 and byte 4).
    typedef enum logic {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

// ===== src/bilinear_pixel_sampler_unit.sv =====
// Bilinear pixel sampler: top level holding the frame store and the sampling pipeline.
// Depends on bps_pkg for widths, codes and the register map.
//
// The block stores one 8-bit grayscale frame and answers sample requests with
// the bilinear interpolation of the four pixels around a fixed-point position.
// Each input word is either a pixel write (op = 0) or a sample request (op = 1);
// one word is taken per clock whenever the output side keeps up, writes and
// samples freely mixed. A write takes effect in the cycle it is accepted and
// gives no output word. A sample gives exactly one output word once it has
// gone through the frame read, the weight-times-pixel multiply and the final
// sum, each of which takes one registered stage. The rate of one
// word per cycle is set by the frame store, which is split into four banks by
// row and column parity so that all four neighbours are read through the single
// read port of each bank in the same cycle. Sample positions are unsigned with
// FRAC_BITS fraction bits; neighbour columns and rows are clamped to the active
// width and height, and a register value of zero acts as one while a value above
// the store size acts as that size. Writes outside the store are dropped. The
// store has no reset: a sample must only touch pixels that have been written.
// Configuration goes through an APB-style port with active_width at byte
// address 0 and active_height at byte address 4; the user must write it only
// while the block is idle, which the block itself does not enforce. The pipeline
// stages collapse bubbles, so a result waiting at the output lets those behind it fill.
module bilinear_pixel_sampler_unit
    import bps_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // Input word channel.
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [OP_W-1:0]        i_op,
    input  logic [PIX_COORD_W-1:0] i_pixel_col,
    input  logic [PIX_COORD_W-1:0] i_pixel_row,
    input  logic [PIX_W-1:0]       i_pixel_value,
    input  logic [SAMPLE_W-1:0]    i_sample_x,
    input  logic [SAMPLE_W-1:0]    i_sample_y,

    // Output word channel.
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_sample_value,

    // Configuration port.
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Derived sizes.
    // ------------------------------------------------------------------
    // Column and row indices are carried with at least two bits so that the
    // parity bit and the in-bank half index are always both present.
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CHW  = (CW > 1) ? CW - 1 : 1;
    localparam int CIW  = CHW + 1;
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RHW  = (RW > 1) ? RW - 1 : 1;
    localparam int RIW  = RHW + 1;
    localparam int AW   = RHW + CHW;
    localparam int BANK_DEPTH = 1 << AW;
    localparam int NBANK = 4;

    // Fixed-point sizes. A weight is the product of two (FRAC_BITS+1)-bit
    // factors; the four weights always sum to exactly one.
    localparam int FW   = FRAC_BITS + 1;
    localparam int WTW  = 2 * FW;
    localparam int PRW  = WTW + PIX_W;
    localparam int ACW  = PRW + 2;
    localparam int RES_LSB = 2 * FRAC_BITS;

    localparam logic [FW-1:0]  FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [ACW-1:0] ROUND_HALF = ACW'(1) << (RES_LSB - 1);

    localparam int RST_W = (MAX_WIDTH  > REG_MAX) ? REG_MAX : MAX_WIDTH;
    localparam int RST_H = (MAX_HEIGHT > REG_MAX) ? REG_MAX : MAX_HEIGHT;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [REG_W-1:0] r_active_width;
    logic [REG_W-1:0] r_active_height;
    logic             cfg_write;
    t_reg_idx         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = t_reg_idx'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= REG_W'(RST_W);
            r_active_height <= REG_W'(RST_H);
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_ACTIVE_WIDTH:  r_active_width  <= pwdata[REG_W-1:0];
                REG_ACTIVE_HEIGHT: r_active_height <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ACTIVE_WIDTH:  prdata = PDATA_W'(r_active_width);
            REG_ACTIVE_HEIGHT: prdata = PDATA_W'(r_active_height);
            default:           prdata = '0;
        endcase
    end

    // Effective frame size: zero acts as one, anything above the store size
    // acts as the store size.
    logic [CMP_W-1:0] lim_w;
    logic [CMP_W-1:0] lim_h;
    logic [CMP_W-1:0] last_col;
    logic [CMP_W-1:0] last_row;

    always_comb begin
        if (r_active_width == '0) begin
            lim_w = CMP_W'(1);
        end else if (CMP_W'(r_active_width) > CMP_W'(MAX_WIDTH)) begin
            lim_w = CMP_W'(MAX_WIDTH);
        end else begin
            lim_w = CMP_W'(r_active_width);
        end
        if (r_active_height == '0) begin
            lim_h = CMP_W'(1);
        end else if (CMP_W'(r_active_height) > CMP_W'(MAX_HEIGHT)) begin
            lim_h = CMP_W'(MAX_HEIGHT);
        end else begin
            lim_h = CMP_W'(r_active_height);
        end
    end

    assign last_col = lim_w - CMP_W'(1);
    assign last_row = lim_h - CMP_W'(1);

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage moves on when it is empty or the
    // stage after it moves on, so bubbles close up and a waiting result in
    // the output register does not stop the stages behind it from filling.
    // ------------------------------------------------------------------
    logic r_v1;
    logic r_v2;
    logic r_out_valid;
    logic en_out;
    logic en2;
    logic en1;
    logic accept;
    logic acc_sample;
    logic acc_write;

    assign en_out     = !r_out_valid || !i_stall;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign o_stall    = !en1;
    assign accept     = i_valid && en1;
    assign acc_sample = accept && (i_op == OP_SAMPLE);
    assign acc_write  = accept && (i_op == OP_WRITE);

    // ------------------------------------------------------------------
    // Acceptance stage: neighbour coordinates, clamping and weights.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-FRAC_BITS-1:0] xi;
    logic [SAMPLE_W-FRAC_BITS-1:0] yi;
    logic [FRAC_BITS-1:0]          fx;
    logic [FRAC_BITS-1:0]          fy;
    logic [FW-1:0]                 gx;
    logic [FW-1:0]                 gy;
    logic [CMP_W-1:0]              x0_full;
    logic [CMP_W-1:0]              x1_full;
    logic [CMP_W-1:0]              y0_full;
    logic [CMP_W-1:0]              y1_full;
    logic [CMP_W-1:0]              c0_full;
    logic [CMP_W-1:0]              c1_full;
    logic [CMP_W-1:0]              rw0_full;
    logic [CMP_W-1:0]              rw1_full;
    logic [CIW-1:0]                c0;
    logic [CIW-1:0]                c1;
    logic [RIW-1:0]                rw0;
    logic [RIW-1:0]                rw1;
    logic [WTW-1:0]                wt [NBANK];

    assign xi = i_sample_x[SAMPLE_W-1:FRAC_BITS];
    assign yi = i_sample_y[SAMPLE_W-1:FRAC_BITS];
    assign fx = i_sample_x[FRAC_BITS-1:0];
    assign fy = i_sample_y[FRAC_BITS-1:0];
    assign gx = FRAC_ONE - FW'(fx);
    assign gy = FRAC_ONE - FW'(fy);

    assign x0_full = CMP_W'(xi);
    assign x1_full = x0_full + CMP_W'(1);
    assign y0_full = CMP_W'(yi);
    assign y1_full = y0_full + CMP_W'(1);

    assign c0_full  = (x0_full > last_col) ? last_col : x0_full;
    assign c1_full  = (x1_full > last_col) ? last_col : x1_full;
    assign rw0_full = (y0_full > last_row) ? last_row : y0_full;
    assign rw1_full = (y1_full > last_row) ? last_row : y1_full;

    assign c0  = c0_full[CIW-1:0];
    assign c1  = c1_full[CIW-1:0];
    assign rw0 = rw0_full[RIW-1:0];
    assign rw1 = rw1_full[RIW-1:0];

    // Weights in neighbour order: top-left, top-right, bottom-left, bottom-right.
    assign wt[0] = gx * gy;
    assign wt[1] = FW'(fx) * gy;
    assign wt[2] = gx * FW'(fy);
    assign wt[3] = FW'(fx) * FW'(fy);

    // Pixel write decode. Writes beyond the store are dropped.
    logic [CMP_W-1:0] wcol_full;
    logic [CMP_W-1:0] wrow_full;
    logic             wr_in_range;
    logic [CIW-1:0]   wcol;
    logic [RIW-1:0]   wrow;
    logic [AW-1:0]    wr_addr;

    assign wcol_full   = CMP_W'(i_pixel_col);
    assign wrow_full   = CMP_W'(i_pixel_row);
    assign wr_in_range = (wcol_full < CMP_W'(MAX_WIDTH)) && (wrow_full < CMP_W'(MAX_HEIGHT));
    assign wcol        = wcol_full[CIW-1:0];
    assign wrow        = wrow_full[RIW-1:0];
    assign wr_addr     = {wrow[RIW-1:1], wcol[CIW-1:1]};

    // ------------------------------------------------------------------
    // Frame store: four banks selected by {row parity, column parity}.
    // Each bank reads the row and column of its own parity, so clamped
    // neighbours that collapse onto one pixel simply share a bank.
    // ------------------------------------------------------------------
    t_pix bank_q [NBANK];

    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        localparam logic ROW_PAR = (b >= 2) ? 1'b1 : 1'b0;
        localparam logic COL_PAR = ((b % 2) == 1) ? 1'b1 : 1'b0;

        t_pix           r_mem [BANK_DEPTH];
        t_pix           r_q;
        logic [RIW-1:0] rd_row;
        logic [CIW-1:0] rd_col;
        logic [AW-1:0]  rd_addr;
        logic           wr_en;

        assign rd_row  = (rw0[0] == ROW_PAR) ? rw0 : rw1;
        assign rd_col  = (c0[0] == COL_PAR) ? c0 : c1;
        assign rd_addr = {rd_row[RIW-1:1], rd_col[CIW-1:1]};
        assign wr_en   = acc_write && wr_in_range &&
                         (wrow[0] == ROW_PAR) && (wcol[0] == COL_PAR);

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_addr] <= i_pixel_value;
            end
            if (acc_sample) begin
                r_q <= r_mem[rd_addr];
            end
        end

        assign bank_q[b] = r_q;
    end

    // ------------------------------------------------------------------
    // Stage 1: bank data is available; pick the four neighbours and multiply
    // by their weights.
    // ------------------------------------------------------------------
    logic [WTW-1:0] r_wt [NBANK];
    logic           r_r0_par;
    logic           r_r1_par;
    logic           r_c0_par;
    logic           r_c1_par;

    always_ff @(posedge i_clk) begin
        if (acc_sample) begin
            r_wt     <= wt;
            r_r0_par <= rw0[0];
            r_r1_par <= rw1[0];
            r_c0_par <= c0[0];
            r_c1_par <= c1[0];
        end
    end

    t_pix           nb_pix [NBANK];
    logic [PRW-1:0] prod   [NBANK];

    assign nb_pix[0] = bank_q[{r_r0_par, r_c0_par}];
    assign nb_pix[1] = bank_q[{r_r0_par, r_c1_par}];
    assign nb_pix[2] = bank_q[{r_r1_par, r_c0_par}];
    assign nb_pix[3] = bank_q[{r_r1_par, r_c1_par}];

    for (genvar k = 0; k < NBANK; k++) begin : g_mul
        assign prod[k] = r_wt[k] * nb_pix[k];
    end

    // ------------------------------------------------------------------
    // Stage 2: sum the weighted pixels, add one half and truncate.
    // ------------------------------------------------------------------
    logic [PRW-1:0] r_prod [NBANK];
    logic [ACW-1:0] acc_sum;

    always_ff @(posedge i_clk) begin
        if (r_v1 && en2) begin
            r_prod <= prod;
        end
    end

    assign acc_sum = ACW'(r_prod[0]) + ACW'(r_prod[1]) + ACW'(r_prod[2])
                   + ACW'(r_prod[3]) + ROUND_HALF;

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    t_pix r_out_value;

    always_ff @(posedge i_clk) begin
        if (r_v2 && en_out) begin
            r_out_value <= acc_sum[RES_LSB+PIX_W-1:RES_LSB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= acc_sample;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_out_valid <= r_v2;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = r_out_value;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A pixel write never enters the sampling pipeline.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_write |=> !r_v1)
        else $error("pixel write entered the sampling pipeline");

    // An accepted sample always occupies the first stage on the next cycle.
    a_sample_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_sample |=> r_v1)
        else $error("accepted sample was lost at the frame read");

    // A finished sum moves into a free output register without delay.
    a_out_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en_out) |=> o_valid)
        else $error("result did not reach the output register");

    // The input side is held only while every stage is occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

endmodule
